>>> src/qfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfm_pkg
// Shared constants for the quadraphonic FM multiplex encoder.
// ----------------------------------------------------------------------------
package qfm_pkg;

   // default geometry
   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int PHASE_WIDTH_DEF    = 32;
   localparam int SINE_ADDR_BITS_DEF = 10;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int GAIN_W      = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_LEVEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONO_GAIN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PILOT_GAIN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN38_GAIN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS38_GAIN = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN76_GAIN = 3'd6;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] PHASE_STEP_RST = 32'd425022805;
   localparam logic [GAIN_W-1:0]     CLIP_LEVEL_RST = 15'd13926;
   localparam logic [GAIN_W-1:0]     MONO_GAIN_RST  = 15'd14746;
   localparam logic [GAIN_W-1:0]     PILOT_GAIN_RST = 15'd573;
   localparam logic [GAIN_W-1:0]     SUB_GAIN_RST   = 15'd11469;

   // odd polynomial sine, Q15 coefficients
   localparam logic [15:0] SIN_C1 = 16'd51472;
   localparam logic [15:0] SIN_C3 = 16'd21024;
   localparam logic [15:0] SIN_C5 = 16'd2320;
   localparam logic [14:0] SIN_MAX = 15'd32767;

endpackage

>>> src/qfm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfm_req_if / qfm_rsp_if
// Valid/ready channels: four-sample audio frame in, one multiplex sample out.
// ----------------------------------------------------------------------------
interface qfm_req_if
   import qfm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] fl_sample;
   logic signed [SAMPLE_WIDTH-1:0] fr_sample;
   logic signed [SAMPLE_WIDTH-1:0] rl_sample;
   logic signed [SAMPLE_WIDTH-1:0] rr_sample;

   modport source (
      output valid, fl_sample, fr_sample, rl_sample, rr_sample,
      input  ready
   );
   modport sink (
      input  valid, fl_sample, fr_sample, rl_sample, rr_sample,
      output ready
   );
endinterface

interface qfm_rsp_if
   import qfm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] mpx_sample;

   modport source (
      output valid, mpx_sample,
      input  ready
   );
   modport sink (
      input  valid, mpx_sample,
      output ready
   );
endinterface

>>> src/quadraphonic_fm_mpx_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadraphonic_fm_mpx_encoder_top
// Quadraphonic FM multiplex encoder built around one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_ch   in   valid/ready          fl_sample, fr_sample, rl_sample,
//                                     rr_sample (signed SAMPLE_WIDTH)
//  rsp_ch   out  valid/ready          mpx_sample (signed SAMPLE_WIDTH)
//  csr_*    in   csr_wr_en only       csr_index, csr_wdata
//
//  From acceptance to the next acceptance one word passes through 24
//  products on the single multiplier (four polynomial sines, gains,
//  differences, mono) plus clip/sum, drain, rounding and idle steps.
//  The result sits in an output register; a new word is taken while it waits,
//  and the sequencer only holds in its last step if that register is full.
//  Synchronous active-high reset restores register defaults and zero phase.
// ----------------------------------------------------------------------------
module quadraphonic_fm_mpx_encoder_top
   import qfm_pkg::*;
#(
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int PHASE_WIDTH    = PHASE_WIDTH_DEF,
   parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   qfm_req_if.sink                req_ch,
   qfm_rsp_if.source              rsp_ch,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int PW     = PHASE_WIDTH;
   localparam int AB     = SINE_ADDR_BITS;
   localparam int LIM_W  = SW - 1;
   localparam int SUM_W  = SW + 2;
   localparam int MA_W   = 32;
   localparam int MB_W   = (SW + 2 > 17) ? SW + 2 : 17;
   localparam int PROD_W = MA_W + MB_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int Q_W    = ACC_W - 32;
   localparam int X_SHIFT = 17 - AB;

   localparam logic [PW-1:0]   HALF_TURN    = PW'(1) << (PW - 1);
   localparam logic [PW-1:0]   QUARTER_TURN = PW'(1) << (PW - 2);
   localparam logic [AB-2:0]   QUARTER_PTS  = (AB - 1)'(1) << (AB - 2);
   localparam logic signed [Q_W-1:0] Q_MAX  = Q_W'((1 << (SW - 1)) - 1);
   localparam logic signed [Q_W-1:0] Q_MIN  = -Q_MAX - Q_W'(1);
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << 31;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_MONO  = 3'd2;
   localparam logic [2:0] ST_SINE  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // steps within one sine term
   localparam logic [2:0] J_SQ   = 3'd0;
   localparam logic [2:0] J_C5   = 3'd1;
   localparam logic [2:0] J_C3   = 3'd2;
   localparam logic [2:0] J_C1   = 3'd3;
   localparam logic [2:0] J_GAIN = 3'd4;
   localparam logic [2:0] J_DIFF = 3'd5;

   // which sine term
   localparam logic [1:0] K_PILOT = 2'd0;
   localparam logic [1:0] K_S38   = 2'd1;
   localparam logic [1:0] K_C38   = 2'd2;
   localparam logic [1:0] K_S76   = 2'd3;

   // how the registered product enters the accumulator
   localparam logic [1:0] ADD_NONE  = 2'd0;
   localparam logic [1:0] ADD_MONO  = 2'd1;
   localparam logic [1:0] ADD_PILOT = 2'd2;
   localparam logic [1:0] ADD_PLAIN = 2'd3;

   // configuration registers
   logic [CSR_DATA_W-1:0] phase_step_ff;
   logic [GAIN_W-1:0]     clip_level_ff;
   logic [GAIN_W-1:0]     mono_gain_ff;
   logic [GAIN_W-1:0]     pilot_gain_ff;
   logic [GAIN_W-1:0]     sin38_gain_ff;
   logic [GAIN_W-1:0]     cos38_gain_ff;
   logic [GAIN_W-1:0]     sin76_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RST;
         clip_level_ff <= CLIP_LEVEL_RST;
         mono_gain_ff  <= MONO_GAIN_RST;
         pilot_gain_ff <= PILOT_GAIN_RST;
         sin38_gain_ff <= SUB_GAIN_RST;
         cos38_gain_ff <= SUB_GAIN_RST;
         sin76_gain_ff <= SUB_GAIN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata;
            CSR_CLIP_LEVEL: clip_level_ff <= csr_wdata[GAIN_W-1:0];
            CSR_MONO_GAIN:  mono_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_PILOT_GAIN: pilot_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_SIN38_GAIN: sin38_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_COS38_GAIN: cos38_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_SIN76_GAIN: sin76_gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // state
   logic [2:0]              state_ff, state_in;
   logic [2:0]              j_ff, j_in;
   logic [1:0]              k_ff, k_in;
   logic [1:0]              add_sel_ff, add_sel_in;
   logic [PW-1:0]           pilot_phase_ff;
   logic                    rsp_valid_ff;
   logic signed [SW-1:0]    mpx_ff;
   logic signed [SW-1:0]    lf_ff, rf_ff, lr_ff, rr_ff;
   logic signed [SUM_W-1:0] m_ff, d1_ff, d2_ff, d3_ff;
   logic [15:0]             x_ff, x2_ff;
   logic                    neg_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   logic req_fire, out_free, done_go;
   assign req_fire = req_ch.valid & req_ch.ready;
   assign out_free = ~rsp_valid_ff | rsp_ch.ready;
   assign done_go  = (state_ff == ST_DONE) & out_free;

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mpx_sample = mpx_ff;

   // clip limit scaled to the sample format
   logic [22:0]      lim_wide;
   logic [LIM_W-1:0] lim;
   assign lim_wide = {clip_level_ff, 8'd0} >> (24 - SW);
   assign lim      = lim_wide[LIM_W-1:0];

   function automatic logic signed [SW-1:0] clip_f(input logic signed [SW-1:0] v,
                                                    input logic [LIM_W-1:0]    l);
      logic signed [SW-1:0] pos;
      logic signed [SW-1:0] neg;
      pos = $signed({1'b0, l});
      neg = -pos;
      if (v > pos)
         clip_f = pos;
      else if (v < neg)
         clip_f = neg;
      else
         clip_f = v;
   endfunction

   always_ff @(posedge clock) begin
      if (req_fire) begin
         lf_ff <= clip_f(req_ch.fl_sample, lim);
         rf_ff <= clip_f(req_ch.fr_sample, lim);
         lr_ff <= clip_f(req_ch.rl_sample, lim);
         rr_ff <= clip_f(req_ch.rr_sample, lim);
      end
   end

   // mono and difference sums
   logic signed [SUM_W-1:0] lf_x, rf_x, lr_x, rr_x;
   assign lf_x = SUM_W'(lf_ff);
   assign rf_x = SUM_W'(rf_ff);
   assign lr_x = SUM_W'(lr_ff);
   assign rr_x = SUM_W'(rr_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_PREP) begin
         m_ff  <= lf_x + rf_x + lr_x + rr_x;
         d1_ff <= (lf_x + lr_x) - (rf_x + rr_x);
         d2_ff <= (lf_x + rr_x) - (lr_x + rf_x);
         d3_ff <= (lf_x + rf_x) - (lr_x + rr_x);
      end
   end

   // phase of the current sine term, folded into the first quadrant
   logic [PW-1:0] p38, c38p, p76, sel_phase;
   logic [AB-1:0] idx;
   logic [AB-2:0] r_fold;
   logic [15:0]   x_sel;

   assign p38  = (pilot_phase_ff << 1) + HALF_TURN;
   assign c38p = p38 + QUARTER_TURN;
   assign p76  = pilot_phase_ff << 2;

   always_comb begin
      case (k_ff)
         K_PILOT: sel_phase = pilot_phase_ff;
         K_S38:   sel_phase = p38;
         K_C38:   sel_phase = c38p;
         default: sel_phase = p76;
      endcase
   end

   assign idx    = sel_phase[PW-1 -: AB];
   assign r_fold = idx[AB-2] ? QUARTER_PTS - {1'b0, idx[AB-3:0]} : {1'b0, idx[AB-3:0]};
   assign x_sel  = 16'(r_fold) << X_SHIFT;

   // operand selection for the shared multiplier
   logic [15:0]             prod_q15;
   logic [14:0]             y_mag;
   logic signed [16:0]      y_signed;
   logic [GAIN_W-1:0]       gain_sel;
   logic signed [SUM_W-1:0] diff_sel;
   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;

   assign prod_q15 = prod_ff[30:15];
   assign y_mag    = (prod_q15 > 16'(SIN_MAX)) ? SIN_MAX : prod_q15[14:0];
   assign y_signed = neg_ff ? -$signed({2'b00, y_mag}) : $signed({2'b00, y_mag});

   always_comb begin
      case (k_ff)
         K_PILOT: gain_sel = pilot_gain_ff;
         K_S38:   gain_sel = sin38_gain_ff;
         K_C38:   gain_sel = cos38_gain_ff;
         default: gain_sel = sin76_gain_ff;
      endcase
   end

   always_comb begin
      case (k_ff)
         K_S38:   diff_sel = d1_ff;
         K_C38:   diff_sel = d2_ff;
         default: diff_sel = d3_ff;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_MONO) begin
         mul_a = MA_W'($signed({1'b0, mono_gain_ff}));
         mul_b = MB_W'(m_ff);
      end else if (state_ff == ST_SINE) begin
         case (j_ff)
            J_SQ: begin
               mul_a = MA_W'($signed({1'b0, x_sel}));
               mul_b = MB_W'($signed({1'b0, x_sel}));
            end
            J_C5: begin
               mul_a = MA_W'($signed({1'b0, SIN_C5}));
               mul_b = MB_W'($signed({1'b0, prod_q15}));
            end
            J_C3: begin
               mul_a = MA_W'($signed({1'b0, SIN_C3 - prod_q15}));
               mul_b = MB_W'($signed({1'b0, x2_ff}));
            end
            J_C1: begin
               mul_a = MA_W'($signed({1'b0, SIN_C1 - prod_q15}));
               mul_b = MB_W'($signed({1'b0, x_ff}));
            end
            J_GAIN: begin
               mul_a = MA_W'($signed({1'b0, gain_sel}));
               mul_b = MB_W'(y_signed);
            end
            J_DIFF: begin
               // signed sine times gain fits in 31 bits
               mul_a = prod_ff[MA_W-1:0];
               mul_b = MB_W'(diff_sel);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (state_ff == ST_SINE && j_ff == J_SQ) begin
         x_ff   <= x_sel;
         neg_ff <= idx[AB-1];
      end
      if (state_ff == ST_SINE && j_ff == J_C5)
         x2_ff <= prod_q15;
   end

   // accumulator, fed from the product register in the cycle after a final product is launched
   logic signed [ACC_W-1:0] prod_x, acc_add;
   assign prod_x = ACC_W'(prod_ff);

   always_comb begin
      case (add_sel_ff)
         ADD_MONO:  acc_add = prod_x <<< 15;
         ADD_PILOT: acc_add = prod_x <<< (SW + 1);
         ADD_PLAIN: acc_add = prod_x;
         default:   acc_add = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         acc_ff <= '0;
      else
         acc_ff <= acc_ff + acc_add;
   end

   // round half up, saturate
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [Q_W-1:0]   q_val;
   logic signed [SW-1:0]    q_sat;
   assign acc_rnd = acc_ff + RND_HALF;
   assign q_val   = acc_rnd[ACC_W-1:32];
   assign q_sat   = (q_val > Q_MAX) ? SW'(Q_MAX) :
                    (q_val < Q_MIN) ? SW'(Q_MIN) : SW'(q_val);

   always_ff @(posedge clock) begin
      if (done_go)
         mpx_ff <= q_sat;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      add_sel_in = ADD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire)
               state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_MONO;
         ST_MONO: begin
            add_sel_in = ADD_MONO;
            state_in   = ST_SINE;
            j_in       = J_SQ;
            k_in       = K_PILOT;
         end
         ST_SINE: begin
            if ((j_ff == J_GAIN && k_ff == K_PILOT) || j_ff == J_DIFF) begin
               add_sel_in = (k_ff == K_PILOT) ? ADD_PILOT : ADD_PLAIN;
               j_in       = J_SQ;
               if (k_ff == K_S76)
                  state_in = ST_DRAIN;
               else
                  k_in = k_ff + 2'd1;
            end else begin
               j_in = j_ff + 3'd1;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         j_ff           <= J_SQ;
         k_ff           <= K_PILOT;
         add_sel_ff     <= ADD_NONE;
         pilot_phase_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         j_ff       <= j_in;
         k_ff       <= k_in;
         add_sel_ff <= add_sel_in;
         if (done_go) begin
            pilot_phase_ff <= pilot_phase_ff + phase_step_ff[CSR_DATA_W-1 -: PW];
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_PREP)
      else $error("accepted word did not start the sequencer");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside the final step");

   a_phase_at_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && pilot_phase_ff != $past(pilot_phase_ff))
         |-> $past(state_ff) == ST_DONE)
      else $error("pilot phase moved mid-word");

   a_pilot_no_diff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SINE && k_ff == K_PILOT) |-> j_ff != J_DIFF)
      else $error("pilot term reached the difference step");
`endif

endmodule
